@@ rtl/core/lru_pkg.sv @@
// ============================================================================
// lru_pkg - shared types and constants for the LRU recency list
// Block count, field widths, operation codes and the control command bundle.
// ============================================================================
package lru_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int BLK_W      = 4;
    localparam int OP_W       = 2;
    localparam int OCC_W      = 5;
    localparam int POS_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam logic [OP_W-1:0] OP_TOUCH   = 2'd0;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL   = 2'd2;

    typedef struct packed {
        logic cap;     // latch request fields
        logic find;    // look up key, register position
        logic update;  // apply list change, load result register
    } t_cmd;

endpackage

@@ rtl/core/lru_if.sv @@
// ============================================================================
// lru_if - request and result channels
// Valid/ready channels carrying LRU requests and replacement results.
// ============================================================================
interface lru_in_if;
    logic                          valid;
    logic                          ready;
    logic [lru_pkg::OP_W-1:0]      operation;
    logic [lru_pkg::BLK_W-1:0]     block_index;
    logic                          free_present;
    logic [lru_pkg::BLK_W-1:0]     free_index;

    modport source (output valid, operation, block_index, free_present, free_index,
                    input ready);
    modport sink   (input valid, operation, block_index, free_present, free_index,
                    output ready);
endinterface

interface lru_out_if;
    logic                          valid;
    logic                          ready;
    logic [lru_pkg::BLK_W-1:0]     victim_block;
    logic                          victim_valid;
    logic [lru_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, victim_block, victim_valid, occupancy, input ready);
    modport sink   (input valid, victim_block, victim_valid, occupancy, output ready);
endinterface

@@ rtl/core/lru_ctrl.sv @@
// ============================================================================
// lru_ctrl - sequencer for the LRU recency list
// Steps each request through capture, lookup and update; owns result valid.
// ============================================================================
module lru_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    output lru_pkg::t_cmd o_cmd
);
    import lru_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIND   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the result register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_rsp_valid = o_cmd.update ? 1'b1 : (i_rsp_ready ? 1'b0 : r_rsp_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

@@ rtl/core/lru_dp.sv @@
// ============================================================================
// lru_dp - datapath of the LRU recency list
// Holds the list entries, length, lookup result and the result register.
// ============================================================================
module lru_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lru_pkg::t_cmd              i_cmd,
    input  logic [lru_pkg::OP_W-1:0]   i_operation,
    input  logic [lru_pkg::BLK_W-1:0]  i_block_index,
    input  logic                       i_free_present,
    input  logic [lru_pkg::BLK_W-1:0]  i_free_index,
    output logic [lru_pkg::BLK_W-1:0]  o_victim_block,
    output logic                       o_victim_valid,
    output logic [lru_pkg::OCC_W-1:0]  o_occupancy
);
    import lru_pkg::*;

    // captured request
    logic [OP_W-1:0]  r_op;
    logic [BLK_W-1:0] r_blk;
    logic             r_free_p;
    logic [BLK_W-1:0] r_free_idx;

    // list state
    logic [BLK_W-1:0] r_entry [NUM_BLOCKS];
    logic [BLK_W-1:0] n_entry [NUM_BLOCKS];
    logic [CNT_W-1:0] r_len, n_len;

    // lookup result
    logic [BLK_W-1:0] r_key, n_key;
    logic             r_found, n_found;
    logic [POS_W-1:0] r_pos, n_pos;

    // result register
    logic [BLK_W-1:0] r_victim;
    logic             r_vvalid;
    logic [OCC_W-1:0] r_occ;

    logic move, produce;

    // lookup: key is the rotated head on a replace without a free block
    always_comb begin
        if (r_op == OP_REPLACE) begin
            n_key = r_free_p ? r_free_idx : r_entry[0];
        end else begin
            n_key = r_blk;
        end
        n_found = 1'b0;
        n_pos   = '0;
        // downward scan, lowest match wins
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_len) && (r_entry[i] == n_key)) begin
                n_found = 1'b1;
                n_pos   = POS_W'(i);
            end
        end
    end

    assign produce = (r_op == OP_REPLACE) && (r_free_p || (r_len != '0));
    assign move    = (r_op == OP_TOUCH) || produce;

    // update: close the gap at the match and write the key at the tail; a miss appends, an invalidate empties the list
    always_comb begin
        n_len = r_len;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            n_entry[i] = r_entry[i];
            if (move && r_found) begin
                if ((i < NUM_BLOCKS - 1) && (POS_W'(i) >= r_pos)
                        && (CNT_W'(i) < r_len - CNT_W'(1))) begin
                    n_entry[i] = r_entry[(i < NUM_BLOCKS - 1) ? i + 1 : i];
                end
                if (CNT_W'(i) == r_len - CNT_W'(1)) begin
                    n_entry[i] = r_key;
                end
            end else if (move && (CNT_W'(i) == r_len)) begin
                n_entry[i] = r_key;
            end
        end
        if (move && !r_found && (r_len < CNT_W'(NUM_BLOCKS))) begin
            n_len = r_len + CNT_W'(1);
        end
        if (r_op == OP_INVAL) begin
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.update) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op       <= i_operation;
            r_blk      <= i_block_index;
            r_free_p   <= i_free_present;
            r_free_idx <= i_free_index;
        end
        if (i_cmd.find) begin
            r_key   <= n_key;
            r_found <= n_found;
            r_pos   <= n_pos;
        end
        if (i_cmd.update) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_entry[i] <= n_entry[i];
            end
            r_victim <= produce ? r_key : '0;
            r_vvalid <= produce;
            r_occ    <= OCC_W'(n_len);
        end
    end

    assign o_victim_block = r_victim;
    assign o_victim_valid = r_vvalid;
    assign o_occupancy    = r_occ;

endmodule

@@ rtl/core/lru_replacement_list.sv @@
// ============================================================================
// lru_replacement_list - LRU recency list for cache block replacement
// A request's fields are captured at the accepting edge; it then passes the
// parallel-lookup and shift-update steps, and update loads the result register
// (stalling while an old result waits). A new request is taken only in idle.
// Reset (synchronous, active low) empties the list; entries need no clearing.
// ============================================================================
module lru_replacement_list (
    input  logic i_clk,
    input  logic i_rst_n,
    lru_in_if.sink    i_req,
    lru_out_if.source o_rsp
);
    import lru_pkg::*;

    // Request flow:
    //   IDLE   - request taken, fields latched
    //   FIND   - all live entries compared with the key at once, first hit
    //            position registered (the key is the head on a rotate)
    //   UPDATE - entries behind the hit shift one place toward the head and
    //            the key lands at the tail; a miss appends when there is room
    // The result register sits between the list and the result channel, so
    // a new request can be taken while a result is still waiting; UPDATE
    // only stalls when the result register is still occupied.

    t_cmd cmd;

    lru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    lru_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_req.operation),
        .i_block_index  (i_req.block_index),
        .i_free_present (i_req.free_present),
        .i_free_index   (i_req.free_index),
        .o_victim_block (o_rsp.victim_block),
        .o_victim_valid (o_rsp.victim_valid),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule
